[rtl/tfd_pkg.sv]
package tfd_pkg;

   // Frame layout
   localparam int FRAME_BYTES = 56;
   localparam int FRAME_AW    = 6;               // byte offset inside one frame buffer
   localparam int RAM_AW      = FRAME_AW + 1;    // bank bit on top of the offset
   localparam int RAM_DEPTH   = 1 << RAM_AW;
   localparam int BYTE_W      = 8;
   localparam logic [FRAME_AW-1:0] COUNT_POS = FRAME_AW'(52);
   localparam logic [FRAME_AW-1:0] LAST_POS  = FRAME_AW'(FRAME_BYTES - 1);

   localparam int FINGERS_DEF = 10;

   // Field widths
   localparam int KIND_W  = 2;
   localparam int SLOT_W  = 4;
   localparam int COORD_W = 13;
   localparam int LIFT_W  = 10;
   localparam int RAW_W   = 16;

   // Config port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] CSR_MAX_X      = 2'd0;
   localparam logic [1:0] CSR_MAX_Y      = 2'd1;
   localparam logic [1:0] CSR_LIFT_TICKS = 2'd2;

   localparam logic [COORD_W-1:0] MAX_X_RST      = COORD_W'(1600);
   localparam logic [COORD_W-1:0] MAX_Y_RST      = COORD_W'(2560);
   localparam logic [LIFT_W-1:0]  LIFT_TICKS_RST = LIFT_W'(80);

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_TICK = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   // Frame assembler status seen by the report sequencer
   typedef struct packed {
      logic have_good;
      logic good_bank;
   } frame_stat_type;

   // Commands from the input channel to the report sequencer
   typedef struct packed {
      logic start;   // burst end with a good frame on hand
      logic tick;
      logic bank;    // bank holding the good frame
   } rpt_cmd_type;

   typedef struct packed {
      logic [COORD_W-1:0] max_x;
      logic [COORD_W-1:0] max_y;
      logic [LIFT_W-1:0]  lift_ticks;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic               down;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } rsp_type;

endpackage

[rtl/tfd_ram.sv]
module tfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tfd_frame.sv]
module tfd_frame (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        byte_en,
   input  logic [tfd_pkg::BYTE_W-1:0]  byte_data,
   input  logic                        burst_end,
   output logic                        wr_en,
   output logic [tfd_pkg::RAM_AW-1:0]  wr_addr,
   output logic [tfd_pkg::BYTE_W-1:0]  wr_data,
   output tfd_pkg::frame_stat_type     stat
);
   import tfd_pkg::*;

   // Two frame buffers; a good frame is kept by swapping banks, not copying.
   logic [FRAME_AW-1:0] idx_ff, idx_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic                saw_ff, saw_in;
   logic                work_bank_ff, work_bank_in;
   logic                good_bank_ff, good_bank_in;
   logic                have_good_ff, have_good_in;
   logic [BYTE_W-1:0]   sum_next;
   logic                saw_next;

   assign sum_next = sum_ff + byte_data;
   assign saw_next = saw_ff | (byte_data != 8'hff);

   always_comb begin
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      saw_in       = saw_ff;
      work_bank_in = work_bank_ff;
      good_bank_in = good_bank_ff;
      have_good_in = have_good_ff;
      if (byte_en) begin
         if (idx_ff == LAST_POS) begin
            idx_in = '0;
            sum_in = '0;
            saw_in = 1'b0;
            if (saw_next && (sum_next == '0)) begin
               good_bank_in = work_bank_ff;
               work_bank_in = ~work_bank_ff;
               have_good_in = 1'b1;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
            sum_in = sum_next;
            saw_in = saw_next;
         end
      end else if (burst_end) begin
         idx_in       = '0;
         sum_in       = '0;
         saw_in       = 1'b0;
         have_good_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         sum_ff       <= '0;
         saw_ff       <= 1'b0;
         work_bank_ff <= 1'b0;
         good_bank_ff <= 1'b1;
         have_good_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         saw_ff       <= saw_in;
         work_bank_ff <= work_bank_in;
         good_bank_ff <= good_bank_in;
         have_good_ff <= have_good_in;
      end
   end

   assign wr_en          = byte_en;
   assign wr_addr        = {work_bank_ff, idx_ff};
   assign wr_data        = byte_data;
   assign stat.have_good = have_good_ff;
   assign stat.good_bank = good_bank_ff;

endmodule

[rtl/tfd_report.sv]
module tfd_report #(
   parameter int FINGERS = tfd_pkg::FINGERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tfd_pkg::rpt_cmd_type        cmd,
   input  tfd_pkg::cfg_type            cfg,
   output logic                        idle,
   output logic                        rd_en,
   output logic [tfd_pkg::RAM_AW-1:0]  rd_addr,
   input  logic [tfd_pkg::BYTE_W-1:0]  rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tfd_pkg::rsp_type            rsp
);
   import tfd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SLOT,
      ST_FETCH,
      ST_EMIT,
      ST_RELEASE
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FINGERS - 1);
   localparam logic [SLOT_W-1:0] MAX_N     = SLOT_W'(FINGERS);

   state_type            state_ff, state_in;
   logic                 bank_ff, bank_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [2:0]           k_ff, k_in;
   logic [2*RAW_W-1:0]   raw_ff, raw_in;
   logic                 use_raw_ff, use_raw_in;
   logic [SLOT_W-1:0]    n_ff, n_in;
   logic [SLOT_W-1:0]    active_ff, active_in;
   logic                 any_ff, any_in;
   logic                 fingers_ff, fingers_in;
   logic                 streak_ff, streak_in;
   logic                 armed_ff, armed_in;
   logic [LIFT_W-1:0]    lcount_ff, lcount_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 out_free;
   logic [LIFT_W-1:0]    lcount_next;
   logic [SLOT_W-1:0]    nib;
   logic [SLOT_W-1:0]    count;
   logic [RAW_W-1:0]     rx, ry;
   logic                 ok;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign lcount_next = (lcount_ff == '1) ? lcount_ff : lcount_ff + 1'b1;

   // point count: 0xff means none, else low nibble capped at FINGERS
   assign nib   = (rd_data == 8'hff) ? '0 : rd_data[SLOT_W-1:0];
   assign count = (nib > MAX_N) ? MAX_N : nib;

   assign rx = raw_ff[2*RAW_W-1:RAW_W];
   assign ry = raw_ff[RAW_W-1:0];
   assign ok = use_raw_ff && (rx != 16'hffff) && (ry != 16'hffff)
               && (rx[RAW_W-1:3] <= cfg.max_x) && (ry[RAW_W-1:3] <= cfg.max_y);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = {cmd.bank, COUNT_POS};
      case (state_ff)
         ST_IDLE: begin
            rd_en = cmd.start;
         end
         ST_FETCH: begin
            rd_en   = (k_ff < 3'd4);
            rd_addr = {bank_ff, slot_ff, k_ff[1:0]};
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      slot_in      = slot_ff;
      k_in         = k_ff;
      raw_in       = raw_ff;
      use_raw_in   = use_raw_ff;
      n_in         = n_ff;
      active_in    = active_ff;
      any_in       = any_ff;
      fingers_in   = fingers_ff;
      streak_in    = streak_ff;
      armed_in     = armed_ff;
      lcount_in    = lcount_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               bank_in  = cmd.bank;
               state_in = ST_COUNT;
            end else if (cmd.tick && armed_ff) begin
               lcount_in = lcount_next;
               if (lcount_next >= cfg.lift_ticks) begin
                  armed_in = 1'b0;
                  if (fingers_ff) begin
                     slot_in  = '0;
                     state_in = ST_RELEASE;
                  end
               end
            end
         end
         ST_COUNT: begin
            if (count == '0) begin
               if (fingers_ff && !streak_ff) begin
                  streak_in = 1'b1;
                  lcount_in = '0;
                  armed_in  = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  armed_in = 1'b0;
                  slot_in  = '0;
                  state_in = fingers_ff ? ST_RELEASE : ST_IDLE;
               end
            end else begin
               streak_in = 1'b0;
               n_in      = count;
               active_in = '0;
               any_in    = 1'b0;
               slot_in   = '0;
               state_in  = ST_SLOT;
            end
         end
         ST_SLOT: begin
            k_in = '0;
            if (active_ff < n_ff) begin
               use_raw_in = 1'b1;
               state_in   = ST_FETCH;
            end else begin
               use_raw_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_FETCH: begin
            if (k_ff != '0) begin
               raw_in = {raw_ff[2*RAW_W-BYTE_W-1:0], rd_data};
            end
            k_in = k_ff + 1'b1;
            if (k_ff == 3'd4) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.slot  = slot_ff;
               rsp_in.down  = ok;
               rsp_in.x     = ok ? rx[RAW_W-1:3] : '0;
               rsp_in.y     = ok ? ry[RAW_W-1:3] : '0;
               rsp_in.last  = (slot_ff == LAST_SLOT);
               if (ok) begin
                  active_in = active_ff + 1'b1;
                  any_in    = 1'b1;
               end
               if (slot_ff == LAST_SLOT) begin
                  fingers_in = any_ff || ok;
                  armed_in   = any_ff || ok;
                  if (any_ff || ok) begin
                     lcount_in = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_SLOT;
               end
            end
         end
         ST_RELEASE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.slot  = slot_ff;
               rsp_in.down  = 1'b0;
               rsp_in.x     = '0;
               rsp_in.y     = '0;
               rsp_in.last  = (slot_ff == LAST_SLOT);
               if (slot_ff == LAST_SLOT) begin
                  fingers_in = 1'b0;
                  streak_in  = 1'b0;
                  state_in   = ST_IDLE;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         slot_ff      <= '0;
         k_ff         <= '0;
         raw_ff       <= '0;
         use_raw_ff   <= 1'b0;
         n_ff         <= '0;
         active_ff    <= '0;
         any_ff       <= 1'b0;
         fingers_ff   <= 1'b0;
         streak_ff    <= 1'b0;
         armed_ff     <= 1'b0;
         lcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         slot_ff      <= slot_in;
         k_ff         <= k_in;
         raw_ff       <= raw_in;
         use_raw_ff   <= use_raw_in;
         n_ff         <= n_in;
         active_ff    <= active_in;
         any_ff       <= any_in;
         fingers_ff   <= fingers_in;
         streak_ff    <= streak_in;
         armed_ff     <= armed_in;
         lcount_ff    <= lcount_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign idle      = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/touch_frame_decoder_top.sv]
// Touch frame decoder. Event bytes (req_tuser = byte) are written one per
// cycle, while the report sequencer is idle, into a 128 x 8 frame memory
// split in two 64-byte banks that each hold a 56-byte frame; a complete
// frame that is not all 0xff and sums to zero mod 256 becomes the good frame
// by a bank swap. A burst end with a good frame reads it back through the
// single read port and, if it holds points, sends one transfer per finger
// slot on rsp; a second empty frame or the lift timer (counted in tick
// items) releases every slot. Rate: bytes and ticks are taken one per
// cycle, back to back, while the sequencer is idle. A report holds req_tready
// low while it reads the count byte, fetches the four coordinate bytes of
// each slot that needs them, one byte per cycle, and emits each slot,
// stalling on rsp; a release holds it low too. The result register lets the
// last transfer of a report wait while the next input item is taken.
module touch_frame_decoder_top #(
   parameter int FINGERS = tfd_pkg::FINGERS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] data
   input  logic [tfd_pkg::KIND_W-1:0]  req_tuser,   // [1:0] kind
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // [3:0] slot, [4] down,
                                                    // [17:5] x, [30:18] y
   output logic                        rsp_tlast,
   // config port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tfd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [tfd_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [tfd_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import tfd_pkg::*;

   logic                accept;
   kind_type            kind;
   logic                byte_en;
   logic                burst_end;
   logic                tick;
   frame_stat_type      stat;
   rpt_cmd_type         cmd;
   cfg_type             cfg_ff, cfg_in;
   logic                csr_wr;
   logic                rpt_idle;
   logic                wr_en;
   logic [RAM_AW-1:0]   wr_addr;
   logic [BYTE_W-1:0]   wr_data;
   logic                rd_en;
   logic [RAM_AW-1:0]   rd_addr;
   logic [BYTE_W-1:0]   rd_data;
   rsp_type             rsp;

   // --- input decode: one transfer per item, taken only while the report sequencer is idle
   assign req_tready = rpt_idle;
   assign accept     = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign byte_en    = accept && (kind == KIND_BYTE);
   assign burst_end  = accept && (kind == KIND_END);
   assign tick       = accept && (kind == KIND_TICK);

   // report only when the burst produced a good frame
   assign cmd.start = burst_end && stat.have_good;
   assign cmd.tick  = tick;
   assign cmd.bank  = stat.good_bank;

   // --- config registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            CSR_MAX_X:      cfg_in.max_x      = csr_pwdata[COORD_W-1:0];
            CSR_MAX_Y:      cfg_in.max_y      = csr_pwdata[COORD_W-1:0];
            CSR_LIFT_TICKS: cfg_in.lift_ticks = csr_pwdata[LIFT_W-1:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_x      <= MAX_X_RST;
         cfg_ff.max_y      <= MAX_Y_RST;
         cfg_ff.lift_ticks <= LIFT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         CSR_MAX_X:      csr_prdata = CSR_DW'(cfg_ff.max_x);
         CSR_MAX_Y:      csr_prdata = CSR_DW'(cfg_ff.max_y);
         CSR_LIFT_TICKS: csr_prdata = CSR_DW'(cfg_ff.lift_ticks);
         default:        csr_prdata = '0;
      endcase
   end

   // --- frame assembly (write side of the frame memory)
   tfd_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .byte_data (req_tdata),
      .burst_end (burst_end),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .stat      (stat)
   );

   // --- frame memory: two banks, one write and one registered read port
   tfd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // --- report sequencer, lift timer and result register
   tfd_report #(
      .FINGERS (FINGERS)
   ) u_report (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cfg       (cfg_ff),
      .idle      (rpt_idle),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.y, rsp.x, rsp.down, rsp.slot};
   assign rsp_tlast = rsp.last;

endmodule
